>>> sv/luf_pkg.sv
// ----------------------------------------------------------------------------
// luf_pkg
// Shared types and constants for the list union dedup filter: op codes,
// word widths, default store capacity and the link carried between cells.
// ----------------------------------------------------------------------------
package luf_pkg;

    // word widths
    localparam int LUF_DATA_W = 32;
    localparam int LUF_OP_W   = 2;

    // default number of store cells
    localparam int LUF_CAPACITY = 64;

    // op codes carried on the input tuser
    localparam logic [LUF_OP_W-1:0] LUF_OP_FIRST  = 2'd0;
    localparam logic [LUF_OP_W-1:0] LUF_OP_SECOND = 2'd1;
    localparam logic [LUF_OP_W-1:0] LUF_OP_CLEAR  = 2'd2;

    // search token and running hit flag passed from cell to cell
    typedef struct packed {
        logic tok;
        logic hit;
    } luf_link_t;

endpackage

>>> sv/luf_cell.sv
// ----------------------------------------------------------------------------
// luf_cell
// One store entry of the union filter. Holds a stored value, compares it
// with the search key when the token passes, and hands token and hit on.
// ----------------------------------------------------------------------------
module luf_cell
    import luf_pkg::*;
#(
    parameter int INDEX = 0,
    parameter int CNT_W = 7
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic signed [LUF_DATA_W-1:0] key,
    input  logic        [CNT_W-1:0]      count,
    input  logic                         wr_en,
    input  luf_link_t                    link_in,
    output luf_link_t                    link_out
);

    logic signed [LUF_DATA_W-1:0] data_reg;
    logic signed [LUF_DATA_W-1:0] data_next;
    luf_link_t                    link_reg;
    luf_link_t                    link_next;
    logic                         active;
    logic                         sel;

    // entry holds a live value only below the fill count
    assign active = (CNT_W'(INDEX) < count);
    assign sel    = wr_en && (count == CNT_W'(INDEX));

    // compare as the token passes, write at the fill position
    always_comb
    begin
        data_next     = sel ? key : data_reg;
        link_next.tok = link_in.tok;
        link_next.hit = link_in.hit | (link_in.tok & active & (data_reg == key));
    end

    // stored value
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    // link stage to the next cell
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_reg <= '0;
        end
        else
        begin
            link_reg <= link_next;
        end
    end

    assign link_out = link_reg;

endmodule

>>> sv/list_union_dedup_filter_core.sv
// ----------------------------------------------------------------------------
// list_union_dedup_filter_core
// Streaming union of two lists over a row of store cells.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries input words: tuser[1:0] is the op (first list, second list,
//   clear), tdata[31:0] the signed value. m_* carries result words:
//   tdata[31:0] the union value, tuser[0] the dropped flag.
//   A first-list value is stored and sent out without any check. A
//   second-list value is searched for across the stored entries: a token
//   walks the row of CAPACITY cells one cell per cycle; a word found there
//   is not sent out, one not found is added. One word is in work at a time.
//   When the store is full, a value that would be added is sent with the
//   dropped flag and not stored.
//   Reset empties the store at once (fill count to zero); no clearing pass.
//   The result sits in an output register: a new input word is taken while
//   a result waits, and a finished word waits for the register while the
//   receiver stalls.
// ----------------------------------------------------------------------------
module list_union_dedup_filter_core
    import luf_pkg::*;
#(
    parameter int CAPACITY = LUF_CAPACITY
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [LUF_DATA_W-1:0] s_tdata,   // [31:0] value
    input  logic [LUF_OP_W-1:0]   s_tuser,   // [1:0] op
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [LUF_DATA_W-1:0] m_tdata,   // [31:0] union_value
    output logic [0:0]            m_tuser    // [0] dropped
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_EMIT
    } state_t;

    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [LUF_DATA_W-1:0]  key_reg, key_next;
    logic                   start_reg, start_next;
    logic                   m_valid_reg, m_valid_next;
    logic [LUF_DATA_W-1:0]  m_data_reg, m_data_next;
    logic                   m_drop_reg, m_drop_next;

    luf_link_t              link [CAPACITY+1];
    logic                   accept;
    logic                   out_free;
    logic                   full;
    logic                   wr_en;

    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign full     = (count_reg == CNT_W'(CAPACITY));
    assign wr_en    = (state_reg == ST_EMIT) && out_free && !full;

    // token enters the row the cycle after a second-list word is taken
    assign link[0].tok = start_reg;
    assign link[0].hit = 1'b0;

    // row of store cells
    for (genvar k = 0; k < CAPACITY; k++)
    begin : g_cell
        luf_cell #(
            .INDEX (k),
            .CNT_W (CNT_W)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .key      (key_reg),
            .count    (count_reg),
            .wr_en    (wr_en),
            .link_in  (link[k]),
            .link_out (link[k+1])
        );
    end

    // sequencer next state
    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        key_next     = key_reg;
        start_next   = 1'b0;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        m_drop_next  = m_drop_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    key_next = s_tdata;
                    unique case (s_tuser)
                        LUF_OP_FIRST:
                        begin
                            state_next = ST_EMIT;
                        end
                        LUF_OP_SECOND:
                        begin
                            start_next = 1'b1;
                            state_next = ST_SEARCH;
                        end
                        LUF_OP_CLEAR:
                        begin
                            count_next = '0;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SEARCH:
            begin
                if (link[CAPACITY].tok)
                begin
                    state_next = link[CAPACITY].hit ? ST_IDLE : ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = key_reg;
                    m_drop_next  = full;
                    if (!full)
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sequencer state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            key_reg     <= '0;
            start_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
            m_data_reg  <= '0;
            m_drop_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            key_reg     <= key_next;
            start_reg   <= start_next;
            m_valid_reg <= m_valid_next;
            m_data_reg  <= m_data_next;
            m_drop_reg  <= m_drop_next;
        end
    end

    assign s_tready   = (state_reg == ST_IDLE);
    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tuser[0] = m_drop_reg;

endmodule

>>> sv/luf_checks.sv
// ----------------------------------------------------------------------------
// luf_checks
// Port-level checks for the list union dedup filter, bound to the top level.
// ----------------------------------------------------------------------------
module luf_checks
    import luf_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic [LUF_OP_W-1:0]   s_tuser,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [LUF_DATA_W-1:0] m_tdata,
    input logic [0:0]            m_tuser
);

    // stalled result word stays offered
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result word withdrawn under stall");

    // stalled result word keeps its payload
    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result payload changed under stall");

    // a list value keeps the block busy for at least the next cycle
    a_busy_after_value: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == LUF_OP_FIRST || s_tuser == LUF_OP_SECOND)
        |=> !s_tready)
        else $error("input taken again right after a list value");

    // a clear or unused op leaves the input ready again in the next cycle
    a_clear_quick: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !(s_tuser == LUF_OP_FIRST || s_tuser == LUF_OP_SECOND)
        |=> s_tready)
        else $error("input not ready after clear or unused op");

endmodule

bind list_union_dedup_filter_core luf_checks u_luf_checks (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

>>> verif/tb_list_union_dedup_filter_core.sv
// ----------------------------------------------------------------------------
// tb_list_union_dedup_filter_core
// Self-checking bench for the list union filter. A queue of input words,
// built up front from directed cases and random rounds (mixed lists over
// small value pools, store fill and overflow runs, raw noise), feeds a
// bursty driver. Each accepted word updates a local copy of the union store.
// That copy predicts the result word, and the monitor compares each result
// word in order against the prediction. The receiver stalls on patterns of
// its own.
// ----------------------------------------------------------------------------
module tb_list_union_dedup_filter_core;
    import luf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STORE_DEPTH    = LUF_CAPACITY;
    localparam int WORD_TARGET    = 1700;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 60;

    // op code that the block ignores
    localparam logic [LUF_OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct {
        logic [LUF_OP_W-1:0]   op;
        logic [LUF_DATA_W-1:0] value;
        bit                    wait_drain;
    } in_word_t;

    typedef struct {
        logic signed [LUF_DATA_W-1:0] union_value;
        logic                         dropped;
    } union_word_t;

    typedef enum logic [1:0] {
        RX_FREE,
        RX_COIN,
        RX_COMB,
        RX_BLOCKS
    } rx_mode_t;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [LUF_DATA_W-1:0] s_tdata  = '0;
    logic [LUF_OP_W-1:0]   s_tuser  = LUF_OP_FIRST;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [LUF_DATA_W-1:0] m_tdata;
    logic [0:0]            m_tuser;

    // stimulus and expectation stores
    in_word_t    pending_words [$];
    union_word_t union_expect_q [$];
    bit          drain_before_next = 1'b0;
    int          words_planned     = 0;
    logic        drained           = 1'b1;
    int          mismatch_count    = 0;
    int          quiet_cycles      = 0;

    // local copy of the union store
    logic [LUF_DATA_W-1:0] union_store_copy [STORE_DEPTH];
    int                    union_fill = 0;

    list_union_dedup_filter_core u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // queue one input word, carrying any pending drain request
    task automatic add_word(input logic [LUF_OP_W-1:0] op, input logic [LUF_DATA_W-1:0] value);
        in_word_t w;
        w.op              = op;
        w.value           = value;
        w.wait_drain      = drain_before_next;
        drain_before_next = 1'b0;
        pending_words.push_back(w);
        if (op != OP_UNUSED)
        begin
            words_planned++;
        end
    endtask

    // update the store copy for one word; returns 1 when a result word follows
    function automatic bit predict_union(input logic [LUF_OP_W-1:0] op,
                                         input logic [LUF_DATA_W-1:0] value,
                                         output union_word_t res);
        bit found;
        bit add;
        found = 1'b0;
        add   = 1'b0;
        res.union_value = '0;
        res.dropped     = 1'b0;
        if (op == LUF_OP_FIRST)
        begin
            add = 1'b1;
        end
        else if (op == LUF_OP_SECOND)
        begin
            for (int i = 0; i < union_fill; i++)
            begin
                if (union_store_copy[i] == value)
                begin
                    found = 1'b1;
                end
            end
            add = !found;
        end
        else if (op == LUF_OP_CLEAR)
        begin
            union_fill = 0;
        end
        if (add)
        begin
            res.union_value = value;
            res.dropped     = (union_fill >= STORE_DEPTH);
            if (!res.dropped)
            begin
                union_store_copy[union_fill] = value;
                union_fill++;
            end
        end
        return add;
    endfunction

    // value drawn for a small pool: extremes, tiny values, random words
    function automatic logic [LUF_DATA_W-1:0] pool_value();
        logic [LUF_DATA_W-1:0] v;
        case ($urandom_range(0, 6))
            0: v = 32'h0000_0000;
            1: v = 32'hFFFF_FFFF;
            2: v = 32'h7FFF_FFFF;
            3: v = 32'h8000_0000;
            4: v = $urandom_range(0, 15);
            default: v = $urandom;
        endcase
        // sometimes a single bit off, to probe the compare
        if ($urandom_range(0, 3) == 0)
        begin
            v = v ^ (32'h1 << $urandom_range(0, 31));
        end
        return v;
    endfunction

    // input word driver: bursts of random length, random gaps
    int burst_left = 1;
    int gap_left   = 0;

    always @(posedge clk or negedge rst_n)
    begin : word_driver
        in_word_t nxt;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= LUF_OP_FIRST;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (gap_left != 0)
            begin
                gap_left--;
                s_tvalid <= 1'b0;
            end
            else if (pending_words.size() == 0)
            begin
                s_tvalid <= 1'b0;
            end
            else if (pending_words[0].wait_drain && (s_tvalid || !drained))
            begin
                // hold off until every outstanding result word is back
                s_tvalid <= 1'b0;
            end
            else
            begin
                nxt = pending_words.pop_front();
                s_tdata  <= nxt.value;
                s_tuser  <= nxt.op;
                s_tvalid <= 1'b1;
                if (burst_left > 1)
                begin
                    burst_left--;
                end
                else
                begin
                    burst_left = $urandom_range(1, 48);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
            end
        end
    end

    // receiver stall patterns, each held for a random stretch
    rx_mode_t rx_mode    = RX_FREE;
    int       rx_left    = 0;
    int       rx_phase   = 0;
    int       stall_left = 0;

    always @(posedge clk or negedge rst_n)
    begin : result_sink
        logic ready;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (rx_left == 0)
            begin
                rx_mode = rx_mode_t'($urandom_range(0, 3));
                rx_left = $urandom_range(50, 400);
            end
            else
            begin
                rx_left--;
            end
            rx_phase++;
            case (rx_mode)
                RX_FREE: ready = 1'b1;
                RX_COIN: ready = 1'($urandom_range(0, 1));
                RX_COMB: ready = (rx_phase % 5) < 3;
                default:
                begin
                    if (stall_left != 0)
                    begin
                        stall_left--;
                        ready = 1'b0;
                    end
                    else if ($urandom_range(0, 15) == 0)
                    begin
                        stall_left = $urandom_range(5, 40);
                        ready      = 1'b0;
                    end
                    else
                    begin
                        ready = 1'b1;
                    end
                end
            endcase
            m_tready <= ready;
        end
    end

    // prediction on accepted input words, checking of result words
    always @(posedge clk)
    begin : union_check
        union_word_t want;
        union_word_t got;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                if (predict_union(s_tuser, s_tdata, want))
                begin
                    union_expect_q.push_back(want);
                end
            end
            if (m_tvalid && m_tready)
            begin
                got.union_value = m_tdata;
                got.dropped     = m_tuser[0];
                if (union_expect_q.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                    begin
                        $error("unexpected result word: union_value %0d dropped %0b",
                               got.union_value, got.dropped);
                    end
                end
                else
                begin
                    want = union_expect_q.pop_front();
                    if (got.union_value !== want.union_value)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                        begin
                            $error("union_value: expected %0d, got %0d",
                                   want.union_value, got.union_value);
                        end
                    end
                    if (got.dropped !== want.dropped)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                        begin
                            $error("dropped: expected %0b, got %0b", want.dropped, got.dropped);
                        end
                    end
                end
            end
        end
        drained <= (union_expect_q.size() == 0);
    end

    // watchdog on cycles with no word moving on either side
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_list_union_dedup_filter_core: errors");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // stimulus, reset and end of run
    initial
    begin : stimulus
        int                    kind;
        int                    len;
        int                    pick;
        bit                    first_round;
        logic [LUF_DATA_W-1:0] pool [0:7];
        logic [LUF_DATA_W-1:0] filled [$];
        logic [LUF_DATA_W-1:0] lost;
        logic [LUF_OP_W-1:0]   op;
        logic [LUF_DATA_W-1:0] v;

        // directed: absent, present, first-list duplicate, extremes
        add_word(LUF_OP_SECOND, 32'h0000_0000);
        add_word(LUF_OP_SECOND, 32'h0000_0000);
        add_word(LUF_OP_FIRST,  32'h0000_0000);
        add_word(LUF_OP_FIRST,  32'h7FFF_FFFF);
        add_word(LUF_OP_FIRST,  32'h8000_0000);
        add_word(LUF_OP_SECOND, 32'hFFFF_FFFF);
        add_word(LUF_OP_SECOND, 32'h8000_0000);
        add_word(LUF_OP_SECOND, 32'h7FFF_FFFE);
        // unused op leaves the store alone
        add_word(OP_UNUSED,     32'h5A5A_5A5A);
        add_word(LUF_OP_SECOND, 32'h5A5A_5A5A);
        add_word(LUF_OP_SECOND, 32'hA5A5_A5A5);
        // clear, then earlier values are absent again
        add_word(LUF_OP_CLEAR,  32'hFFFF_FFFF);
        add_word(LUF_OP_SECOND, 32'h8000_0000);
        add_word(LUF_OP_SECOND, 32'h8000_0000);
        add_word(LUF_OP_SECOND, 32'h7FFF_FFFF);
        add_word(LUF_OP_FIRST,  32'h0000_0001);
        add_word(LUF_OP_SECOND, 32'h0000_0001);
        add_word(LUF_OP_CLEAR,  32'h0000_0000);

        // random rounds; the first is a store fill behind a full drain
        first_round       = 1'b1;
        drain_before_next = 1'b1;
        while (words_planned < WORD_TARGET)
        begin
            kind = first_round ? 0 : $urandom_range(0, 9);
            first_round = 1'b0;
            if (kind <= 2)
            begin
                // fill up to or past capacity, then hits, dropped repeats and misses
                if ($urandom_range(0, 4) != 0)
                begin
                    add_word(LUF_OP_CLEAR, $urandom);
                end
                filled.delete();
                len = $urandom_range(50, 80);
                for (int k = 0; k < len; k++)
                begin
                    if (filled.size() != 0 && $urandom_range(0, 6) == 0)
                    begin
                        v = filled[$urandom_range(0, filled.size() - 1)];
                    end
                    else
                    begin
                        v = $urandom;
                    end
                    add_word(LUF_OP_FIRST, v);
                    filled.push_back(v);
                end
                lost = $urandom;
                len  = $urandom_range(10, 40);
                for (int k = 0; k < len; k++)
                begin
                    pick = $urandom_range(0, 3);
                    if (pick <= 1)
                    begin
                        v = filled[$urandom_range(0, filled.size() - 1)];
                    end
                    else if (pick == 2)
                    begin
                        v = lost;
                    end
                    else
                    begin
                        v = $urandom;
                    end
                    add_word(LUF_OP_SECOND, v);
                end
            end
            else if (kind <= 7)
            begin
                // both lists over a small pool, so hits are common
                for (int i = 0; i < 8; i++)
                begin
                    pool[i] = pool_value();
                end
                if ($urandom_range(0, 1) == 0)
                begin
                    add_word(LUF_OP_CLEAR, $urandom);
                end
                len = $urandom_range(10, 60);
                for (int k = 0; k < len; k++)
                begin
                    pick = $urandom_range(0, 19);
                    if (pick < 6)
                    begin
                        op = LUF_OP_FIRST;
                    end
                    else if (pick < 18)
                    begin
                        op = LUF_OP_SECOND;
                    end
                    else if (pick == 18)
                    begin
                        op = LUF_OP_CLEAR;
                    end
                    else
                    begin
                        op = OP_UNUSED;
                    end
                    v = ($urandom_range(0, 7) == 0) ? $urandom : pool[$urandom_range(0, 7)];
                    add_word(op, v);
                end
            end
            else
            begin
                // raw noise
                len = $urandom_range(3, 15);
                for (int k = 0; k < len; k++)
                begin
                    add_word(LUF_OP_W'($urandom_range(0, 3)), $urandom);
                end
            end
            if ($urandom_range(0, 5) == 0)
            begin
                drain_before_next = 1'b1;
            end
        end

        // reset
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // wait for the last input word, the outstanding results, then the tail
        wait (pending_words.size() == 0);
        @(posedge clk);
        while (s_tvalid)
        begin
            @(posedge clk);
        end
        while (union_expect_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (STORE_DEPTH + 8) @(posedge clk);

        if (mismatch_count == 0)
        begin
            $display("tb_list_union_dedup_filter_core: clean");
        end
        else
        begin
            $display("tb_list_union_dedup_filter_core: errors");
        end
        $finish;
    end

endmodule
